### sv/glyph_string_square_generator_defines.svh
// Assertion macros for the glyph string square generator.
// Used by modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef GLYPH_STRING_SQUARE_GENERATOR_DEFINES_SVH
`define GLYPH_STRING_SQUARE_GENERATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge out of reset.
`define GSSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked at every rising edge out of reset.
`define GSSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GSSG_ASSERT_NOW(label, ante, cons, msg)
`define GSSG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### sv/gssg_pkg.sv
// Package for the glyph string square generator: field widths, glyph codes,
// the 7x5 font table and the font read request type. No dependencies.
`timescale 1ns / 1ps
package gssg_pkg;

	localparam int unsigned GLYPH_COLUMNS  = 7;
	localparam int unsigned GLYPH_ROWS     = 5;
	localparam int unsigned GLYPH_CELLS    = GLYPH_COLUMNS * GLYPH_ROWS;
	localparam int unsigned GLYPH_COUNT    = 39;
	localparam int unsigned GLYPH_IDX_W    = $clog2(GLYPH_COUNT);
	localparam int unsigned ROW_W          = $clog2(GLYPH_ROWS);
	localparam int unsigned COORD_BITS_DEF = 16;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned ORIGIN_W = 16;
	localparam int unsigned SCALE_W  = 5;
	localparam int unsigned COLOR_W  = 32;
	localparam int unsigned STEP_W   = 8;

	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;

	localparam logic [GLYPH_IDX_W-1:0] GLYPH_DIGIT_BASE = 6'd26;
	localparam logic [GLYPH_IDX_W-1:0] GLYPH_SPACE      = 6'd36;
	localparam logic [GLYPH_IDX_W-1:0] GLYPH_COLON      = 6'd37;
	localparam logic [GLYPH_IDX_W-1:0] GLYPH_BOX        = 6'd38;

	typedef struct packed {
		logic                   en;
		logic [GLYPH_IDX_W-1:0] idx;
	} font_req_t;

	function automatic logic [GLYPH_IDX_W-1:0] gssg_glyph_index(input logic [CHAR_W-1:0] code);
		logic [GLYPH_IDX_W-1:0] idx;
		if (code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
			idx = GLYPH_IDX_W'(code - CHAR_UPPER_A);
		end else if (code inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
			idx = GLYPH_IDX_W'(code - CHAR_DIGIT_0) + GLYPH_DIGIT_BASE;
		end else if (code == CHAR_SPACE) begin
			idx = GLYPH_SPACE;
		end else if (code == CHAR_COLON) begin
			idx = GLYPH_COLON;
		end else begin
			idx = GLYPH_BOX;
		end
		return idx;
	endfunction

	// Row-major cells, row 0 in the top bits, column 0 leftmost in each row.
	function automatic logic [GLYPH_CELLS-1:0] gssg_font_rows(input logic [GLYPH_IDX_W-1:0] idx);
		logic [GLYPH_CELLS-1:0] r;
		case (idx)
			6'd0:        r = 35'b0011100_0100010_0111110_0100010_0100010;
			6'd1:        r = 35'b0011100_0100010_0111100_0100010_0111100;
			6'd2:        r = 35'b0011110_0100000_0100000_0100000_0011110;
			6'd3:        r = 35'b0111100_0100010_0100010_0100010_0111100;
			6'd4:        r = 35'b0011100_0100000_0111000_0100000_0011100;
			6'd5:        r = 35'b0011110_0100000_0111100_0100000_0100000;
			6'd6:        r = 35'b0011100_0100000_0100110_0100010_0011100;
			6'd7:        r = 35'b0100010_0100010_0111110_0100010_0100010;
			6'd8:        r = 35'b0111110_0001000_0001000_0001000_0111110;
			6'd9:        r = 35'b0011110_0000010_0000010_0100010_0011100;
			6'd10:       r = 35'b0100010_0100100_0111000_0100100_0100010;
			6'd11:       r = 35'b0100000_0100000_0100000_0100000_0011110;
			6'd12:       r = 35'b0100010_0110110_0101010_0100010_0100010;
			6'd13:       r = 35'b0100010_0110010_0101010_0100110_0100010;
			6'd14:       r = 35'b0011100_0100010_0100010_0100010_0011100;
			6'd15:       r = 35'b0011100_0100010_0111100_0100000_0100000;
			6'd16:       r = 35'b0011100_0100010_0100010_0101010_0010110;
			6'd17:       r = 35'b0011100_0100010_0111100_0100010_0100010;
			6'd18:       r = 35'b0011110_0100000_0011100_0000010_0111100;
			6'd19:       r = 35'b0111110_0001000_0001000_0001000_0001000;
			6'd20:       r = 35'b0100010_0100010_0100010_0100010_0011100;
			6'd21:       r = 35'b0100010_0100010_0010100_0010100_0001000;
			6'd22:       r = 35'b0100010_0100010_0101010_0110110_0011100;
			6'd23:       r = 35'b0100010_0010100_0001000_0010100_0100010;
			6'd24:       r = 35'b0100010_0010100_0001000_0001000_0001000;
			6'd25:       r = 35'b0111110_0000100_0001000_0010000_0111110;
			6'd26:       r = 35'b0011100_0110010_0101010_0100110_0011100;
			6'd27:       r = 35'b0001000_0011000_0001000_0001000_0011100;
			6'd28:       r = 35'b0011100_0100010_0000100_0001000_0111110;
			6'd29:       r = 35'b0111100_0000010_0001100_0000010_0111100;
			6'd30:       r = 35'b0001100_0010100_0100100_0111110_0000100;
			6'd31:       r = 35'b0111110_0100000_0111100_0000010_0111100;
			6'd32:       r = 35'b0011100_0100000_0111100_0100010_0011100;
			6'd33:       r = 35'b0111110_0000010_0000100_0001000_0010000;
			6'd34:       r = 35'b0011100_0100010_0011100_0100010_0011100;
			6'd35:       r = 35'b0011100_0100010_0011110_0000010_0011100;
			GLYPH_SPACE: r = '0;
			GLYPH_COLON: r = 35'b0100000_0100000_0000000_0100000_0100000;
			default:     r = 35'b1111111_1010101_1001001_1010101_1111111;
		endcase
		return r;
	endfunction

endpackage

### sv/glyph_string_square_generator.sv
// Top level of the glyph string square generator: font ROM and sequencer.
// Depends on gssg_pkg, gssg_font_rom and gssg_scan.
//
//   channel  handshake          payload
//   in       in_valid/in_stall  char_code origin_x origin_y scale pixel_color start_of_string
//   out      out_valid/out_stall square_x square_y square_size square_color last_square
//
// An item is accepted and its glyph read from the font ROM; the scan then steps one
// glyph cell per cycle up to its last set cell, unless an output square stalls.
// A space has no set cells and ends after the ROM read. A stalled square freezes
// the scan; the next item is accepted once the scan ends, even while the final
// square still waits. Reset clears the pen offset to zero and drops any item in flight.
`timescale 1ns / 1ps
module glyph_string_square_generator #(
	parameter int unsigned COORD_BITS = gssg_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [gssg_pkg::CHAR_W-1:0]          char_code,
	input  logic signed [gssg_pkg::ORIGIN_W-1:0] origin_x,
	input  logic signed [gssg_pkg::ORIGIN_W-1:0] origin_y,
	input  logic [gssg_pkg::SCALE_W-1:0]         scale,
	input  logic [gssg_pkg::COLOR_W-1:0]         pixel_color,
	input  logic                                 start_of_string,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [gssg_pkg::ORIGIN_W-1:0] square_x,
	output logic signed [gssg_pkg::ORIGIN_W-1:0] square_y,
	output logic [gssg_pkg::SCALE_W-1:0]         square_size,
	output logic [gssg_pkg::COLOR_W-1:0]         square_color,
	output logic                                 last_square
);
	import gssg_pkg::*;

	font_req_t              font_req;
	logic [GLYPH_CELLS-1:0] font_cells;

	gssg_font_rom u_font_rom (
		.clk   (clk),
		.req   (font_req),
		.cells (font_cells)
	);

	gssg_scan #(
		.COORD_BITS (COORD_BITS)
	) u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.char_code       (char_code),
		.origin_x        (origin_x),
		.origin_y        (origin_y),
		.scale           (scale),
		.pixel_color     (pixel_color),
		.start_of_string (start_of_string),
		.font_req        (font_req),
		.font_cells      (font_cells),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.square_x        (square_x),
		.square_y        (square_y),
		.square_size     (square_size),
		.square_color    (square_color),
		.last_square     (last_square)
	);

endmodule

### sv/gssg_font_rom.sv
// Synchronous font ROM: one glyph per read, cells returned column-major
// (bit column*ROWS+row) in the cycle after the request. Depends on gssg_pkg.
`timescale 1ns / 1ps
module gssg_font_rom (
	input  logic                            clk,
	input  gssg_pkg::font_req_t             req,
	output logic [gssg_pkg::GLYPH_CELLS-1:0] cells
);
	import gssg_pkg::*;

	logic [GLYPH_CELLS-1:0] rows;
	logic [GLYPH_CELLS-1:0] col_major;
	logic [GLYPH_CELLS-1:0] cells_q;

	assign rows = gssg_font_rows(req.idx);

	always_comb begin
		for (int c = 0; c < GLYPH_COLUMNS; c++) begin
			for (int r = 0; r < GLYPH_ROWS; r++) begin
				col_major[c * GLYPH_ROWS + r] = rows[GLYPH_CELLS - 1 - (r * GLYPH_COLUMNS + c)];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.en) begin
			cells_q <= col_major;
		end
	end

	assign cells = cells_q;

endmodule

### sv/gssg_scan.sv
// Character sequencer: pen offset, font fetch, cell scan and square output
// register. Depends on gssg_pkg, the assertion macro header and the font ROM read data.
`timescale 1ns / 1ps
`include "glyph_string_square_generator_defines.svh"
module gssg_scan #(
	parameter int unsigned COORD_BITS = gssg_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [gssg_pkg::CHAR_W-1:0]          char_code,
	input  logic signed [gssg_pkg::ORIGIN_W-1:0] origin_x,
	input  logic signed [gssg_pkg::ORIGIN_W-1:0] origin_y,
	input  logic [gssg_pkg::SCALE_W-1:0]         scale,
	input  logic [gssg_pkg::COLOR_W-1:0]         pixel_color,
	input  logic                                 start_of_string,
	output gssg_pkg::font_req_t                  font_req,
	input  logic [gssg_pkg::GLYPH_CELLS-1:0]     font_cells,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [gssg_pkg::ORIGIN_W-1:0] square_x,
	output logic signed [gssg_pkg::ORIGIN_W-1:0] square_y,
	output logic [gssg_pkg::SCALE_W-1:0]         square_size,
	output logic [gssg_pkg::COLOR_W-1:0]         square_color,
	output logic                                 last_square
);
	import gssg_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

	logic [1:0]             state_q;
	logic [COORD_BITS-1:0]  pen_q;
	logic [GLYPH_CELLS-1:0] mask_q;
	logic [ROW_W-1:0]       row_q;
	logic                   out_valid_q;

	logic [COORD_BITS-1:0]  cur_x_q;
	logic [COORD_BITS-1:0]  cur_y_q;
	logic [COORD_BITS-1:0]  base_y_q;
	logic [SCALE_W-1:0]     scale_q;
	logic [COLOR_W-1:0]     color_q;
	logic [ORIGIN_W-1:0]    sq_x_q;
	logic [ORIGIN_W-1:0]    sq_y_q;
	logic [SCALE_W-1:0]     sq_size_q;
	logic [COLOR_W-1:0]     sq_color_q;
	logic                   sq_last_q;

	logic                   accept;
	logic                   adv;
	logic                   rest_empty;
	logic [COORD_BITS-1:0]  pen_eff;
	logic [COORD_BITS-1:0]  ox_c;
	logic [COORD_BITS-1:0]  oy_c;
	logic [STEP_W-1:0]      pen_step;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign adv        = (state_q == ST_SCAN) && (!out_valid_q || !out_stall);
	assign rest_empty = (mask_q[GLYPH_CELLS-1:1] == '0);

	assign pen_eff  = start_of_string ? '0 : pen_q;
	assign ox_c     = COORD_BITS'(origin_x);
	assign oy_c     = COORD_BITS'(origin_y);
	assign pen_step = STEP_W'(scale) * STEP_W'(GLYPH_COLUMNS);

	assign font_req.en  = accept;
	assign font_req.idx = gssg_glyph_index(char_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pen_q       <= '0;
			mask_q      <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pen_q   <= pen_eff + COORD_BITS'(pen_step);
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					mask_q  <= font_cells;
					row_q   <= '0;
					state_q <= (font_cells == '0) ? ST_IDLE : ST_SCAN;
				end
				ST_SCAN: begin
					if (adv) begin
						mask_q <= mask_q >> 1;
						row_q  <= (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
						if (rest_empty) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (adv && mask_q[0]) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q  <= ox_c + pen_eff;
			cur_y_q  <= oy_c;
			base_y_q <= oy_c;
			scale_q  <= scale;
			color_q  <= pixel_color;
		end else if (adv) begin
			if (row_q == ROW_LAST) begin
				cur_x_q <= cur_x_q + COORD_BITS'(scale_q);
				cur_y_q <= base_y_q;
			end else begin
				cur_y_q <= cur_y_q + COORD_BITS'(scale_q);
			end
		end
		if (adv && mask_q[0]) begin
			sq_x_q     <= ORIGIN_W'(cur_x_q);
			sq_y_q     <= ORIGIN_W'(cur_y_q);
			sq_size_q  <= scale_q;
			sq_color_q <= color_q;
			sq_last_q  <= rest_empty;
		end
	end

	assign out_valid    = out_valid_q;
	assign square_x     = sq_x_q;
	assign square_y     = sq_y_q;
	assign square_size  = sq_size_q;
	assign square_color = sq_color_q;
	assign last_square  = sq_last_q;

	`GSSG_ASSERT_NEXT(a_accept_fetch, accept, state_q == ST_FETCH, "accepted item did not fetch")
	`GSSG_ASSERT_NOW(a_scan_mask, state_q == ST_SCAN, mask_q != '0, "scan with no cells left")
	`GSSG_ASSERT_NOW(a_row_range, 1'b1, row_q <= ROW_LAST, "row counter out of range")
	`GSSG_ASSERT_NEXT(a_last_idle, adv && rest_empty, state_q == ST_IDLE, "scan ran past last cell")
	`GSSG_ASSERT_NEXT(a_pen_hold, !accept, $stable(pen_q), "pen moved without an item")

endmodule

### verif/tb.sv
// Self-checking testbench for glyph_string_square_generator: strings of characters
// go in, and every square that comes out is checked against a predicted 7x5 font scan.
// Depends on gssg_pkg for field widths and character codes.
`timescale 1ns / 1ps

import gssg_pkg::*;

typedef struct packed {
	logic [CHAR_W-1:0]   code;
	logic [ORIGIN_W-1:0] ox;
	logic [ORIGIN_W-1:0] oy;
	logic [SCALE_W-1:0]  scale;
	logic [COLOR_W-1:0]  color;
	logic                sos;
} char_item_t;

typedef struct packed {
	logic [ORIGIN_W-1:0] x;
	logic [ORIGIN_W-1:0] y;
	logic [SCALE_W-1:0]  side;
	logic [COLOR_W-1:0]  color;
	logic                last_square;
} square_t;

// One row per element, row 0 first; each row holds seven ASCII cells, column 0 leftmost.
typedef bit [0:GLYPH_ROWS-1][8*GLYPH_COLUMNS-1:0] glyph_art_t;

localparam bit [7:0] INK_CELL = "#";

function automatic glyph_art_t glyph_for(input logic [CHAR_W-1:0] code);
	int unsigned slot;
	glyph_art_t  a;
	if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z)
		slot = code - CHAR_UPPER_A;
	else if (code >= CHAR_DIGIT_0 && code <= CHAR_DIGIT_9)
		slot = GLYPH_DIGIT_BASE + (code - CHAR_DIGIT_0);
	else if (code == CHAR_SPACE)
		slot = GLYPH_SPACE;
	else if (code == CHAR_COLON)
		slot = GLYPH_COLON;
	else
		slot = GLYPH_BOX;
	case (slot)
		0:  a = {"..###..", ".#...#.", ".#####.", ".#...#.", ".#...#."};
		1:  a = {"..###..", ".#...#.", ".####..", ".#...#.", ".####.."};
		2:  a = {"..####.", ".#.....", ".#.....", ".#.....", "..####."};
		3:  a = {".####..", ".#...#.", ".#...#.", ".#...#.", ".####.."};
		4:  a = {"..###..", ".#.....", ".###...", ".#.....", "..###.."};
		5:  a = {"..####.", ".#.....", ".####..", ".#.....", ".#....."};
		6:  a = {"..###..", ".#.....", ".#..##.", ".#...#.", "..###.."};
		7:  a = {".#...#.", ".#...#.", ".#####.", ".#...#.", ".#...#."};
		8:  a = {".#####.", "...#...", "...#...", "...#...", ".#####."};
		9:  a = {"..####.", ".....#.", ".....#.", ".#...#.", "..###.."};
		10: a = {".#...#.", ".#..#..", ".###...", ".#..#..", ".#...#."};
		11: a = {".#.....", ".#.....", ".#.....", ".#.....", "..####."};
		12: a = {".#...#.", ".##.##.", ".#.#.#.", ".#...#.", ".#...#."};
		13: a = {".#...#.", ".##..#.", ".#.#.#.", ".#..##.", ".#...#."};
		14: a = {"..###..", ".#...#.", ".#...#.", ".#...#.", "..###.."};
		15: a = {"..###..", ".#...#.", ".####..", ".#.....", ".#....."};
		16: a = {"..###..", ".#...#.", ".#...#.", ".#.#.#.", "..#.##."};
		17: a = {"..###..", ".#...#.", ".####..", ".#...#.", ".#...#."};
		18: a = {"..####.", ".#.....", "..###..", ".....#.", ".####.."};
		19: a = {".#####.", "...#...", "...#...", "...#...", "...#..."};
		20: a = {".#...#.", ".#...#.", ".#...#.", ".#...#.", "..###.."};
		21: a = {".#...#.", ".#...#.", "..#.#..", "..#.#..", "...#..."};
		22: a = {".#...#.", ".#...#.", ".#.#.#.", ".##.##.", "..###.."};
		23: a = {".#...#.", "..#.#..", "...#...", "..#.#..", ".#...#."};
		24: a = {".#...#.", "..#.#..", "...#...", "...#...", "...#..."};
		25: a = {".#####.", "....#..", "...#...", "..#....", ".#####."};
		26: a = {"..###..", ".##..#.", ".#.#.#.", ".#..##.", "..###.."};
		27: a = {"...#...", "..##...", "...#...", "...#...", "..###.."};
		28: a = {"..###..", ".#...#.", "....#..", "...#...", ".#####."};
		29: a = {".####..", ".....#.", "...##..", ".....#.", ".####.."};
		30: a = {"...##..", "..#.#..", ".#..#..", ".#####.", "....#.."};
		31: a = {".#####.", ".#.....", ".####..", ".....#.", ".####.."};
		32: a = {"..###..", ".#.....", ".####..", ".#...#.", "..###.."};
		33: a = {".#####.", ".....#.", "....#..", "...#...", "..#...."};
		34: a = {"..###..", ".#...#.", "..###..", ".#...#.", "..###.."};
		35: a = {"..###..", ".#...#.", "..####.", ".....#.", "..###.."};
		GLYPH_SPACE: a = {".......", ".......", ".......", ".......", "......."};
		GLYPH_COLON: a = {".#.....", ".#.....", ".......", ".#.....", ".#....."};
		default: a = {"#######", "#.#.#.#", "#..#..#", "#.#.#.#", "#######"};
	endcase
	return a;
endfunction

class square_board;
	square_t             squares_due[$];
	logic [ORIGIN_W-1:0] pen;
	int unsigned         chars_noted;
	int unsigned         squares_checked;
	int unsigned         mismatches;

	function new();
		pen = '0;
		chars_noted = 0;
		squares_checked = 0;
		mismatches = 0;
	endfunction

	function int unsigned pending();
		return squares_due.size();
	endfunction

	function void queue_square(input square_t s);
		squares_due = {squares_due, s};
	endfunction

	function void note_char(input char_item_t c);
		glyph_art_t art;
		square_t    held;
		bit         have_held;
		art = glyph_for(c.code);
		held = '0;
		have_held = 1'b0;
		if (c.sos)
			pen = '0;
		// scan column-major; hold each square until the next one shows it is not the last
		for (int col = 0; col < GLYPH_COLUMNS; col++) begin
			for (int row = 0; row < GLYPH_ROWS; row++) begin
				if (art[row][8*(GLYPH_COLUMNS-1-col) +: 8] == INK_CELL) begin
					if (have_held)
						queue_square(held);
					held.x = c.ox + pen + ORIGIN_W'(col * c.scale);
					held.y = c.oy + ORIGIN_W'(row * c.scale);
					held.side = c.scale;
					held.color = c.color;
					held.last_square = 1'b0;
					have_held = 1'b1;
				end
			end
		end
		if (have_held) begin
			held.last_square = 1'b1;
			queue_square(held);
		end
		pen = pen + ORIGIN_W'(GLYPH_COLUMNS * c.scale);
		chars_noted++;
	endfunction

	function void check_square(input square_t got);
		square_t want;
		squares_checked++;
		if (squares_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected square: x=%h y=%h size=%0d color=%h last=%b",
					got.x, got.y, got.side, got.color, got.last_square);
			return;
		end
		want = squares_due.pop_front();
		if (got.x !== want.x || got.y !== want.y || got.side !== want.side ||
			got.color !== want.color || got.last_square !== want.last_square) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("square %0d mismatch: expected x=%h y=%h size=%0d color=%h last=%b",
					squares_checked, want.x, want.y, want.side, want.color,
					want.last_square);
				$display("    got x=%h y=%h size=%0d color=%h last=%b",
					got.x, got.y, got.side, got.color, got.last_square);
			end
		end
	endfunction
endclass

module tb;
	localparam int unsigned CYCLE_LIMIT      = 1_000_000;
	localparam int unsigned LONG_HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES    = 40;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [CHAR_W-1:0]          char_code;
	logic signed [ORIGIN_W-1:0] origin_x;
	logic signed [ORIGIN_W-1:0] origin_y;
	logic [SCALE_W-1:0]         scale;
	logic [COLOR_W-1:0]         pixel_color;
	logic                       start_of_string;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [ORIGIN_W-1:0] square_x;
	logic signed [ORIGIN_W-1:0] square_y;
	logic [SCALE_W-1:0]         square_size;
	logic [COLOR_W-1:0]         square_color;
	logic                       last_square;

	square_board board;
	int unsigned cycle_count;
	int unsigned items_sent;
	bit          source_idles;
	bit          sink_idles;
	bit          long_hold_req;
	bit          long_hold_active;

	glyph_string_square_generator u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.char_code       (char_code),
		.origin_x        (origin_x),
		.origin_y        (origin_y),
		.scale           (scale),
		.pixel_color     (pixel_color),
		.start_of_string (start_of_string),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.square_x        (square_x),
		.square_y        (square_y),
		.square_size     (square_size),
		.square_color    (square_color),
		.last_square     (last_square)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && in_valid && !in_stall)
			board.note_char(char_item_t'{char_code, origin_x, origin_y, scale,
				pixel_color, start_of_string});
		if (arst_n && out_valid && !out_stall)
			board.check_square(square_t'{square_x, square_y, square_size,
				square_color, last_square});
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : sink_pacing
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				long_hold_active = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold_active = 1'b0;
			end else if (sink_idles && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	function automatic char_item_t make_char(input logic [CHAR_W-1:0] code,
		input logic [ORIGIN_W-1:0] ox, input logic [ORIGIN_W-1:0] oy,
		input logic [SCALE_W-1:0] sc, input logic [COLOR_W-1:0] color, input logic sos);
		char_item_t c;
		c.code = code;
		c.ox = ox;
		c.oy = oy;
		c.scale = sc;
		c.color = color;
		c.sos = sos;
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_code();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 10)
			return CHAR_UPPER_A + CHAR_W'($urandom_range(0, 25));
		else if (pick < 14)
			return CHAR_DIGIT_0 + CHAR_W'($urandom_range(0, 9));
		else if (pick < 16)
			return CHAR_SPACE;
		else if (pick < 17)
			return CHAR_COLON;
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [SCALE_W-1:0] rand_scale();
		if ($urandom_range(0, 9) == 0)
			return SCALE_W'($urandom_range(0, 31));
		return SCALE_W'($urandom_range(1, 16));
	endfunction

	task automatic offer_char(input char_item_t c);
		if (source_idles && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c.code;
		origin_x <= c.ox;
		origin_y <= c.oy;
		scale <= c.scale;
		pixel_color <= c.color;
		start_of_string <= c.sos;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Well-formed strings share origin, scale and color; noisy ones scramble every field.
	task automatic send_string(input int unsigned len, input bit noisy);
		logic [ORIGIN_W-1:0] ox;
		logic [ORIGIN_W-1:0] oy;
		logic [SCALE_W-1:0]  sc;
		logic [COLOR_W-1:0]  color;
		ox = ORIGIN_W'($urandom_range(0, 65535));
		oy = ORIGIN_W'($urandom_range(0, 65535));
		sc = rand_scale();
		color = $urandom;
		for (int i = 0; i < len; i++) begin
			if (noisy)
				offer_char(make_char(CHAR_W'($urandom_range(0, 255)),
					ORIGIN_W'($urandom_range(0, 65535)), ORIGIN_W'($urandom_range(0, 65535)),
					SCALE_W'($urandom_range(0, 31)), $urandom, 1'($urandom_range(0, 1))));
			else
				offer_char(make_char(rand_code(), ox, oy, sc, color, i == 0));
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int unsigned target);
		while (items_sent < target) begin
			if ($urandom_range(0, 6) == 0)
				send_string($urandom_range(1, 3), 1'b1);
			else
				send_string($urandom_range(1, 8), 1'b0);
		end
	endtask

	initial begin
		board = new();
		cycle_count = 0;
		items_sent = 0;
		source_idles = 1'b1;
		sink_idles = 1'b1;
		long_hold_req = 1'b0;
		long_hold_active = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		char_code <= '0;
		origin_x <= '0;
		origin_y <= '0;
		scale <= '0;
		pixel_color <= '0;
		start_of_string <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, every glyph class, codes just outside each range, scale zero and max
		offer_char(make_char(CHAR_UPPER_A, 16'h0000, 16'h0000, 5'd1, 32'h0000_0000, 1'b1));
		offer_char(make_char(CHAR_UPPER_Z, 16'h7FFF, 16'h7FFF, 5'd16, 32'hFFFF_FFFF, 1'b0));
		offer_char(make_char(CHAR_DIGIT_0, 16'h8000, 16'h8000, 5'd31, 32'hA5A5_5A5A, 1'b0));
		offer_char(make_char(CHAR_DIGIT_9, 16'hFFFF, 16'hFFFF, 5'd0, 32'h5A5A_A5A5, 1'b0));
		offer_char(make_char(CHAR_SPACE, 16'h0000, 16'h0000, 5'd5, 32'h1234_5678, 1'b0));
		offer_char(make_char(CHAR_COLON, 16'h0000, 16'h0000, 5'd5, 32'h1234_5678, 1'b0));
		offer_char(make_char("a", 16'h0010, 16'h0020, 5'd2, 32'hDEAD_BEEF, 1'b0));
		offer_char(make_char(8'h00, 16'hFFF0, 16'h7FF0, 5'd31, 32'hFFFF_FFFF, 1'b0));
		offer_char(make_char(8'hFF, 16'h8000, 16'h0000, 5'd16, 32'h0000_0000, 1'b0));
		offer_char(make_char(CHAR_UPPER_A - 1, 16'h0100, 16'h0100, 5'd3, 32'h0F0F_0F0F, 1'b1));
		offer_char(make_char(CHAR_UPPER_Z + 1, 16'h0100, 16'h0100, 5'd3, 32'h0F0F_0F0F, 1'b0));
		offer_char(make_char(CHAR_DIGIT_0 - 1, 16'h0100, 16'h0100, 5'd3, 32'h0F0F_0F0F, 1'b0));
		offer_char(make_char(CHAR_COLON + 1, 16'h0100, 16'h0100, 5'd3, 32'h0F0F_0F0F, 1'b0));
		offer_char(make_char(CHAR_SPACE - 1, 16'h0100, 16'h0100, 5'd3, 32'h0F0F_0F0F, 1'b0));
		offer_char(make_char(CHAR_SPACE + 1, 16'h0100, 16'h0100, 5'd3, 32'h0F0F_0F0F, 1'b0));
		offer_char(make_char(CHAR_SPACE, 16'h0100, 16'h0100, 5'd0, 32'h0F0F_0F0F, 1'b0));
		offer_char(make_char("H", 16'h7FF0, 16'h8001, 5'd16, 32'hFF00_FF00, 1'b1));
		offer_char(make_char("I", 16'h7FF0, 16'h8001, 5'd16, 32'hFF00_FF00, 1'b0));
		offer_char(make_char(CHAR_SPACE, 16'h7FF0, 16'h8001, 5'd16, 32'hFF00_FF00, 1'b0));
		offer_char(make_char("4", 16'h7FF0, 16'h8001, 5'd16, 32'hFF00_FF00, 1'b0));
		offer_char(make_char("2", 16'h7FF0, 16'h8001, 5'd16, 32'hFF00_FF00, 1'b0));
		offer_char(make_char(":", 16'h7FF0, 16'h8001, 5'd16, 32'hFF00_FF00, 1'b0));
		offer_char(make_char("M", 16'hFFFF, 16'h0000, 5'd7, 32'h8000_0001, 1'b1));
		offer_char(make_char("W", 16'hFFFF, 16'h0000, 5'd7, 32'h8000_0001, 1'b0));
		offer_char(make_char("Q", 16'hFFFF, 16'h0000, 5'd7, 32'h8000_0001, 1'b0));
		wait_drained();

		random_phase(120);

		// fill the block behind a long output hold while the source keeps offering
		source_idles = 1'b0;
		long_hold_req = 1'b1;
		in_valid <= 1'b0;
		while (!long_hold_active)
			@(posedge clk);
		send_string(12, 1'b0);
		source_idles = 1'b1;
		wait_drained();

		random_phase(220);

		source_idles = 1'b0;
		sink_idles = 1'b0;
		random_phase(280);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d characters in directed, random and back-pressure phases",
			board.chars_noted);
		$display("checked %0d squares, %0d mismatches", board.squares_checked,
			board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

### files.f
+incdir+sv
sv/gssg_pkg.sv
sv/gssg_font_rom.sv
sv/gssg_scan.sv
sv/glyph_string_square_generator.sv
verif/tb.sv
